// ----- rtl/core/climate_color_bilinear_blend_defines.svh -----
// Assertion helpers for the color blend block.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef CLIMATE_COLOR_BILINEAR_BLEND_DEFINES_SVH
`define CLIMATE_COLOR_BILINEAR_BLEND_DEFINES_SVH

// Same-cycle implication.
`define CCBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CCBB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ccbb_pkg.sv -----
package ccbb_pkg;

  // fraction bits of the t and h coordinates
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned SCALE     = 1 << FRAC_BITS;

  localparam int unsigned TEMP_W = 12;
  localparam int unsigned HUM_W  = 11;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned OUT_W  = 16;

  // t = (T + 160) * S / 320, split as >> 6 then / 5
  localparam int unsigned TEMP_OFS = 160;
  localparam int unsigned T_SHR    = 6;
  localparam int unsigned TY_W     = FRAC_BITS + 4;
  localparam int unsigned TY_LIM   = 10 * SCALE;
  localparam int unsigned T_K      = FRAC_BITS + 6;
  localparam int unsigned T_MW     = FRAC_BITS + 4;
  localparam int unsigned T_M      = ((1 << T_K) + 4) / 5;

  // h = H * S / 800, split as >> 5 then / 25
  localparam int unsigned H_SHR  = 5;
  localparam int unsigned HZ_W   = FRAC_BITS + 6;
  localparam int unsigned HZ_LIM = 50 * SCALE;
  localparam int unsigned H_K    = FRAC_BITS + 11;
  localparam int unsigned H_MW   = FRAC_BITS + 7;
  localparam int unsigned H_M    = ((1 << H_K) + 24) / 25;

  localparam int unsigned COORD_W = FRAC_BITS + 2;  // 0..2S
  localparam int unsigned WGT_W   = FRAC_BITS + 1;  // 0..S
  localparam int unsigned DRY_W   = FRAC_BITS + 8;  // 0..255*S
  localparam int unsigned ROWP_W  = FRAC_BITS + 11;
  localparam int unsigned COLP_W  = 2 * FRAC_BITS + 11;
  localparam int unsigned OUT_SHR = 2 * FRAC_BITS - 8;
  localparam int unsigned OUT_MAX = 255 << 8;

  // [table][t row][h column][channel]; table 0 grass, 1 weed
  localparam logic [CH_W-1:0] CCBB_TAB [2][3][3][3] = '{
    '{
      '{'{8'd126, 8'd148, 8'd100}, '{8'd94,  8'd160, 8'd100}, '{8'd54, 8'd142, 8'd78}},
      '{'{8'd151, 8'd175, 8'd55},  '{8'd108, 8'd190, 8'd49},  '{8'd58, 8'd158, 8'd38}},
      '{'{8'd194, 8'd157, 8'd58},  '{8'd174, 8'd176, 8'd51},  '{8'd89, 8'd154, 8'd36}}
    },
    '{
      '{'{8'd139, 8'd202, 8'd155}, '{8'd116, 8'd195, 8'd144}, '{8'd87, 8'd181, 8'd124}},
      '{'{8'd204, 8'd199, 8'd57},  '{8'd99,  8'd190, 8'd38},  '{8'd43, 8'd163, 8'd27}},
      '{'{8'd240, 8'd211, 8'd69},  '{8'd186, 8'd195, 8'd43},  '{8'd53, 8'd160, 8'd25}}
    }
  };

  typedef struct packed {
    logic en3;  // load row blend stage
    logic en4;  // load column blend stage
  } ccbb_lane_ctrl_t;

endpackage

// ----- rtl/core/ccbb_lane.sv -----
module ccbb_lane import ccbb_pkg::*; (
  input  logic                  clk_i,
  input  ccbb_lane_ctrl_t       ctrl_i,
  input  logic [CH_W-1:0]       a0_i,
  input  logic [CH_W-1:0]       b0_i,
  input  logic [CH_W-1:0]       a1_i,
  input  logic [CH_W-1:0]       b1_i,
  input  logic [WGT_W-1:0]      wt_i,
  input  logic [WGT_W-1:0]      wh_i,
  output logic [OUT_W-1:0]      value_o
);

  // a*S + (b - a)*w, exact, never negative
  function automatic logic [DRY_W-1:0] row_blend(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [WGT_W-1:0] w);
    logic signed [ROWP_W-1:0] diff;
    logic signed [ROWP_W-1:0] prod;
    logic signed [ROWP_W-1:0] sum;
    diff = $signed(ROWP_W'(b)) - $signed(ROWP_W'(a));
    prod = diff * $signed(ROWP_W'(w));
    sum  = $signed(ROWP_W'({a, {FRAC_BITS{1'b0}}})) + prod;
    return sum[DRY_W-1:0];
  endfunction

  logic [DRY_W-1:0]  dry_d, dry_q, wet_d, wet_q;
  logic [WGT_W-1:0]  wh_q;
  logic signed [COLP_W-1:0] col_diff, col_prod, col_sum;
  logic [OUT_W-1:0]  out_d, out_q;

  assign dry_d = row_blend(a0_i, b0_i, wt_i);
  assign wet_d = row_blend(a1_i, b1_i, wt_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en3) begin
      dry_q <= dry_d;
      wet_q <= wet_d;
      wh_q  <= wh_i;
    end
  end

  // dry*S + (wet - dry)*wh, scale S*S, then truncate to 8 fraction bits
  always_comb begin
    col_diff = $signed(COLP_W'(wet_q)) - $signed(COLP_W'(dry_q));
    col_prod = col_diff * $signed(COLP_W'(wh_q));
    col_sum  = $signed(COLP_W'({dry_q, {FRAC_BITS{1'b0}}})) + col_prod;
    out_d    = col_sum[OUT_SHR+OUT_W-1:OUT_SHR];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en4) begin
      out_q <= out_d;
    end
  end

  assign value_o = out_q;

endmodule

// ----- rtl/core/climate_color_bilinear_blend.sv -----
// An accepted item moves through stages 1 to 4; stage 4 valid drives m_tvalid_o.
// Throughput: one item per cycle while m_tready_i is high; the four stage
// registers stall independently, so bubbles close up and s_tready_o stays
// high while any stage can move. Reset (rst_ni low, asynchronous) clears the
// stage valid bits only; no data state is kept between items.
module climate_color_bilinear_blend import ccbb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // [11:0] temperature, [22:12] humidity, [23] zero
  input  logic        s_tuser_i,   // [0] cmd: 0 grass table, 1 weed table
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [47:0] m_tdata_o    // [15:0] red, [31:16] green, [47:32] blue
);

`include "climate_color_bilinear_blend_defines.svh"

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || m_tready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_tready_o = en1;
  assign m_tvalid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: offset, pre-shift and saturation checks.
  // t numerator: (T + 160) * S / 64, forced to 0 when T + 160 <= 0.
  // h numerator: H * S / 32.
  // Beyond 10*S (t) or 50*S (h) the coordinate saturates at 2*S, which
  // keeps the reciprocal multiply below to a narrow, exact range.
  // ---------------------------------------------------------------------
  logic signed [TEMP_W:0]            tnum;
  logic [TEMP_W-1:0]                 tpos;
  logic [TEMP_W+FRAC_BITS-1:0]       y_full;
  logic [HUM_W+FRAC_BITS-1:0]        z_full;
  logic                              cmd1_q, tsat_d, tsat_q, hsat_d, hsat_q;
  logic [TY_W-1:0]                   y_q;
  logic [HZ_W-1:0]                   z_q;

  always_comb begin
    tnum   = $signed({s_tdata_i[TEMP_W-1], s_tdata_i[TEMP_W-1:0]})
           + $signed((TEMP_W+1)'(TEMP_OFS));
    tpos   = (tnum > 0) ? tnum[TEMP_W-1:0] : '0;
    y_full = {tpos, {FRAC_BITS{1'b0}}} >> T_SHR;
    tsat_d = y_full >= (TEMP_W+FRAC_BITS)'(TY_LIM);
    z_full = {s_tdata_i[TEMP_W+HUM_W-1:TEMP_W], {FRAC_BITS{1'b0}}} >> H_SHR;
    hsat_d = z_full >= (HUM_W+FRAC_BITS)'(HZ_LIM);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q <= s_tuser_i;
      y_q    <= y_full[TY_W-1:0];
      tsat_q <= tsat_d;
      z_q    <= z_full[HZ_W-1:0];
      hsat_q <= hsat_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: divide by 5 and by 25 through reciprocal multiplies.
  // The reciprocals are rounded up; the error stays below one quotient
  // step over the unsaturated range, so the floor is exact.
  // ---------------------------------------------------------------------
  logic [TY_W+T_MW-1:0]  t_prod;
  logic [HZ_W+H_MW-1:0]  h_prod;
  logic [COORD_W-1:0]    t_fx_d, t_fx_q, h_fx_d, h_fx_q;
  logic                  cmd2_q;

  always_comb begin
    t_prod = (TY_W+T_MW)'(y_q) * (TY_W+T_MW)'(T_M);
    h_prod = (HZ_W+H_MW)'(z_q) * (HZ_W+H_MW)'(H_M);
    t_fx_d = tsat_q ? COORD_W'(2 * SCALE) : COORD_W'(t_prod[T_K+FRAC_BITS:T_K]);
    h_fx_d = hsat_q ? COORD_W'(2 * SCALE) : COORD_W'(h_prod[H_K+FRAC_BITS:H_K]);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cmd2_q <= cmd1_q;
      t_fx_q <= t_fx_d;
      h_fx_q <= h_fx_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3 (row blend along t) and stage 4 (column blend along h) live in
  // one lane per channel. Cell index is capped at 1, so a coordinate of
  // exactly 2*S picks cell 1 with full weight.
  // ---------------------------------------------------------------------
  logic                  ti, hi;
  logic [1:0]            ti0, ti1, hi0, hi1;
  logic [WGT_W-1:0]      wt, wh;
  logic [CH_W-1:0]       a0 [3];
  logic [CH_W-1:0]       b0 [3];
  logic [CH_W-1:0]       a1 [3];
  logic [CH_W-1:0]       b1 [3];
  logic [OUT_W-1:0]      lane_val [3];
  ccbb_lane_ctrl_t       lane_ctrl;

  always_comb begin
    ti  = t_fx_q[FRAC_BITS] | t_fx_q[FRAC_BITS+1];
    hi  = h_fx_q[FRAC_BITS] | h_fx_q[FRAC_BITS+1];
    // low bits minus the cell base; wraps correctly at exactly 2*S
    wt  = t_fx_q[WGT_W-1:0] - {ti, {FRAC_BITS{1'b0}}};
    wh  = h_fx_q[WGT_W-1:0] - {hi, {FRAC_BITS{1'b0}}};
    ti0 = {1'b0, ti};
    ti1 = {ti, ~ti};
    hi0 = {1'b0, hi};
    hi1 = {hi, ~hi};
  end

  assign lane_ctrl.en3 = en3;
  assign lane_ctrl.en4 = en4;

  for (genvar gi = 0; gi < 3; gi++) begin : g_lane
    assign a0[gi] = CCBB_TAB[cmd2_q][ti0][hi0][2'(gi)];
    assign b0[gi] = CCBB_TAB[cmd2_q][ti1][hi0][2'(gi)];
    assign a1[gi] = CCBB_TAB[cmd2_q][ti0][hi1][2'(gi)];
    assign b1[gi] = CCBB_TAB[cmd2_q][ti1][hi1][2'(gi)];

    ccbb_lane u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lane_ctrl),
      .a0_i    (a0[gi]),
      .b0_i    (b0[gi]),
      .a1_i    (a1[gi]),
      .b1_i    (b1[gi]),
      .wt_i    (wt),
      .wh_i    (wh),
      .value_o (lane_val[gi])
    );
  end

  assign m_tdata_o = {lane_val[2], lane_val[1], lane_val[0]};

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `CCBB_ASSERT_NXT(a_accept_fills_s1, s_tvalid_i && s_tready_o, v1_q,
                   "accepted item did not reach stage 1")
  `CCBB_ASSERT_IMP(a_t_range, v2_q, t_fx_q <= COORD_W'(2 * SCALE),
                   "t coordinate above 2")
  `CCBB_ASSERT_IMP(a_h_range, v2_q, h_fx_q <= COORD_W'(2 * SCALE),
                   "h coordinate above 2")
  `CCBB_ASSERT_IMP(a_out_range, m_tvalid_o,
                   lane_val[0] <= OUT_W'(OUT_MAX) && lane_val[1] <= OUT_W'(OUT_MAX) &&
                   lane_val[2] <= OUT_W'(OUT_MAX),
                   "channel value above 255.0")

endmodule
